FILE: rtl/bts_pkg.sv
// Shared constants and types for the bilinear texture sampler.
// No dependencies; every other file refers to it by scoped names.
package bts_pkg;

  localparam int COORD_W   = 18;
  localparam int TADDR_W   = 16;
  localparam int CHAN_W    = 8;
  localparam int RESULT_W  = 24;
  localparam int DIM_REG_W = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CORNERS   = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'd1;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // corner slots
  localparam int C11 = 0;
  localparam int C01 = 1;
  localparam int C10 = 2;
  localparam int C00 = 3;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } texel_t;

  typedef struct packed {
    logic valid;
    logic sample;
  } stage_ctl_t;

endpackage

FILE: rtl/bts_if.sv
// Valid/ready channel interfaces for sampler items and result items.
// Depends on bts_pkg for field widths.
interface bts_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [bts_pkg::TADDR_W-1:0]       tex_address;
  logic [bts_pkg::CHAN_W-1:0]        red_in;
  logic [bts_pkg::CHAN_W-1:0]        green_in;
  logic [bts_pkg::CHAN_W-1:0]        blue_in;
  logic signed [bts_pkg::COORD_W-1:0] u_coord;
  logic signed [bts_pkg::COORD_W-1:0] v_coord;

  modport source (output valid, mode, tex_address, red_in, green_in, blue_in,
                  u_coord, v_coord, input ready);
  modport sink   (input valid, mode, tex_address, red_in, green_in, blue_in,
                  u_coord, v_coord, output ready);
endinterface

interface bts_out_if;
  logic                         valid;
  logic                         ready;
  logic [bts_pkg::RESULT_W-1:0] red_out;
  logic [bts_pkg::RESULT_W-1:0] green_out;
  logic [bts_pkg::RESULT_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

FILE: rtl/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler: config registers, pipeline
// and output register with skid. Depends on bts_pkg, bts_if, bts_coord,
// bts_texmem and bts_blend.
//
//   port     dir   handshake      payload
//   in_item  sink  valid/ready    mode, tex_address, red/green/blue_in, u/v_coord
//   out_item src   valid/ready    red_out, green_out, blue_out (sample items only)
//   cfg      in    cfg_we         cfg_index, cfg_data
//
// One item per cycle unless stalled; a sample result passes the coordinate
// stages, texel read, blend products and output register. Four texel reads
// per cycle come from two store copies, two read ports each. Reset clears
// config to 1x1 and empties the pipeline; the texel store is not cleared.
// The pipeline stalls only when both output and skid registers are full.
module bilinear_texture_sampler #(
  parameter int TEXEL_DEPTH = 65536,
  parameter int MAX_DIM     = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bts_pkg::DIM_REG_W-1:0]     cfg_data,
  bts_in_if.sink                            in_item,
  bts_out_if.source                         out_item
);

  localparam int AW = $clog2(TEXEL_DEPTH);
  localparam int DW = $clog2(MAX_DIM+1);
  localparam int WW = 2*FRAC_BITS + 1;
  localparam int EW = (bts_pkg::DIM_REG_W > DW) ? bts_pkg::DIM_REG_W : DW;

  // effective dimensions, zero taken as one, saturated to MAX_DIM
  logic [DW-1:0] eff_w, eff_h, eff_new;
  logic [EW-1:0] cfg_ext;

  assign cfg_ext = EW'(cfg_data);

  always_comb begin
    if (cfg_ext == '0) begin
      eff_new = DW'(1);
    end else if (cfg_ext > EW'(MAX_DIM)) begin
      eff_new = DW'(MAX_DIM);
    end else begin
      eff_new = DW'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= DW'(1);
      eff_h <= DW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bts_pkg::CFG_TEX_WIDTH:  eff_w <= eff_new;
        bts_pkg::CFG_TEX_HEIGHT: eff_h <= eff_new;
        default: ;
      endcase
    end
  end

  logic adv;
  logic skid_valid;

  assign adv = !skid_valid;
  assign in_item.ready = adv;

  bts_pkg::stage_ctl_t in_ctl;
  bts_pkg::texel_t     wr_texel;

  assign in_ctl = '{valid: in_item.valid,
                    sample: (in_item.mode == bts_pkg::MODE_SAMPLE)};
  assign wr_texel = '{blue: in_item.blue_in, green: in_item.green_in, red: in_item.red_in};

  bts_pkg::stage_ctl_t s3_ctl, s4_ctl, s5_ctl;
  logic [AW-1:0]       s3_waddr;
  bts_pkg::texel_t     s3_wdata;
  logic [bts_pkg::CORNERS-1:0][AW-1:0] s3_raddr;
  logic [bts_pkg::CORNERS-1:0][WW-1:0] s3_wts, s4_wts;
  bts_pkg::texel_t [bts_pkg::CORNERS-1:0] s4_texel;
  logic [bts_pkg::RESULT_W-1:0] res_r, res_g, res_b;

  bts_coord #(
    .TEXEL_DEPTH(TEXEL_DEPTH),
    .MAX_DIM    (MAX_DIM),
    .FRAC_BITS  (FRAC_BITS)
  ) u_coord (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_ctl     (in_ctl),
    .tex_address(in_item.tex_address),
    .wr_texel   (wr_texel),
    .u_coord    (in_item.u_coord),
    .v_coord    (in_item.v_coord),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .s3_ctl     (s3_ctl),
    .s3_waddr   (s3_waddr),
    .s3_wdata   (s3_wdata),
    .s3_raddr   (s3_raddr),
    .s3_wts     (s3_wts)
  );

  bts_texmem #(
    .TEXEL_DEPTH(TEXEL_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_texmem (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .s3_ctl  (s3_ctl),
    .s3_waddr(s3_waddr),
    .s3_wdata(s3_wdata),
    .s3_raddr(s3_raddr),
    .s3_wts  (s3_wts),
    .s4_ctl  (s4_ctl),
    .s4_texel(s4_texel),
    .s4_wts  (s4_wts)
  );

  bts_blend #(
    .FRAC_BITS(FRAC_BITS)
  ) u_blend (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s4_ctl   (s4_ctl),
    .s4_texel (s4_texel),
    .s4_wts   (s4_wts),
    .s5_ctl   (s5_ctl),
    .red_out  (res_r),
    .green_out(res_g),
    .blue_out (res_b)
  );

  logic res_valid;
  logic out_valid;
  logic [bts_pkg::RESULT_W-1:0] out_r, out_g, out_b;
  logic [bts_pkg::RESULT_W-1:0] skid_r, skid_g, skid_b;

  assign res_valid = adv && s5_ctl.valid && s5_ctl.sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_item.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_item.ready || !out_valid) begin
      if (skid_valid) begin
        out_r <= skid_r;
        out_g <= skid_g;
        out_b <= skid_b;
      end else if (res_valid) begin
        out_r <= res_r;
        out_g <= res_g;
        out_b <= res_b;
      end
    end else if (res_valid) begin
      skid_r <= res_r;
      skid_g <= res_g;
      skid_b <= res_b;
    end
  end

  assign out_item.valid     = out_valid;
  assign out_item.red_out   = out_r;
  assign out_item.green_out = out_g;
  assign out_item.blue_out  = out_b;

endmodule

FILE: rtl/bts_coord.sv
// Coordinate front end: clamp and scale, split and weights, texel addresses.
// Three register stages. Depends on bts_pkg.
module bts_coord #(
  parameter int TEXEL_DEPTH = 65536,
  parameter int MAX_DIM     = 256,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  bts_pkg::stage_ctl_t                 in_ctl,
  input  logic [bts_pkg::TADDR_W-1:0]         tex_address,
  input  bts_pkg::texel_t                     wr_texel,
  input  logic [bts_pkg::COORD_W-1:0]         u_coord,
  input  logic [bts_pkg::COORD_W-1:0]         v_coord,
  input  logic [$clog2(MAX_DIM+1)-1:0]        eff_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]        eff_h,
  output bts_pkg::stage_ctl_t                 s3_ctl,
  output logic [$clog2(TEXEL_DEPTH)-1:0]      s3_waddr,
  output bts_pkg::texel_t                     s3_wdata,
  output logic [bts_pkg::CORNERS-1:0][$clog2(TEXEL_DEPTH)-1:0] s3_raddr,
  output logic [bts_pkg::CORNERS-1:0][2*FRAC_BITS:0]           s3_wts
);

  localparam int AW   = $clog2(TEXEL_DEPTH);
  localparam int DW   = $clog2(MAX_DIM+1);
  localparam int CW   = FRAC_BITS + 1;
  localparam int PW   = CW + DW;
  localparam int WW   = 2*FRAC_BITS + 1;
  localparam int CMPW = (FRAC_BITS + 2 > bts_pkg::COORD_W) ? FRAC_BITS + 2 : bts_pkg::COORD_W;
  localparam int AXW  = (AW > bts_pkg::TADDR_W) ? AW : bts_pkg::TADDR_W;
  localparam int SW   = (2*DW + 1 > AW) ? 2*DW + 1 : AW;

  function automatic logic [CW-1:0] clamp(input logic [bts_pkg::COORD_W-1:0] raw);
    logic [CMPW-1:0] mag;
    logic [CMPW-1:0] one;
    logic [CW-1:0]   res;
    mag = CMPW'(raw[bts_pkg::COORD_W-2:0]);
    one = CMPW'(1) << FRAC_BITS;
    if (raw[bts_pkg::COORD_W-1]) begin
      res = '0;
    end else if (mag > one) begin
      res = CW'(one);
    end else begin
      res = CW'(mag);
    end
    return res;
  endfunction

  // stage 1
  bts_pkg::stage_ctl_t s1_ctl;
  logic [PW-1:0]       s1_pu, s1_pv;
  logic [AW-1:0]       s1_waddr;
  bts_pkg::texel_t     s1_wdata;
  logic [AXW-1:0]      waddr_ext;
  logic [DW-1:0]       wm1, hm1;

  assign waddr_ext = AXW'(tex_address);
  assign wm1 = eff_w - DW'(1);
  assign hm1 = eff_h - DW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pu    <= PW'(clamp(u_coord)) * PW'(wm1);
      s1_pv    <= PW'(clamp(v_coord)) * PW'(hm1);
      s1_waddr <= waddr_ext[AW-1:0];
      s1_wdata <= wr_texel;
    end
  end

  // stage 2
  bts_pkg::stage_ctl_t s2_ctl;
  logic [DW-1:0]        s2_x0;
  logic [2*DW-1:0]      s2_wy0;
  logic                 s2_sx, s2_ty;
  logic [bts_pkg::CORNERS-1:0][WW-1:0] s2_wts;
  logic [AW-1:0]        s2_waddr;
  bts_pkg::texel_t      s2_wdata;
  logic [FRAC_BITS-1:0] s_frac, t_frac;
  logic [DW-1:0]        y0;
  logic [CW-1:0]        s_inv, t_inv;

  assign s_frac = s1_pu[FRAC_BITS-1:0];
  assign t_frac = s1_pv[FRAC_BITS-1:0];
  assign y0     = s1_pv[FRAC_BITS +: DW];
  assign s_inv  = (CW'(1) << FRAC_BITS) - CW'(s_frac);
  assign t_inv  = (CW'(1) << FRAC_BITS) - CW'(t_frac);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (adv) begin
      s2_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_x0  <= s1_pu[FRAC_BITS +: DW];
      s2_wy0 <= (2*DW)'(eff_w) * (2*DW)'(y0);
      s2_sx  <= (s_frac != '0);
      s2_ty  <= (t_frac != '0);
      s2_wts[bts_pkg::C11] <= WW'(s_frac) * WW'(t_frac);
      s2_wts[bts_pkg::C01] <= WW'(s_inv)  * WW'(t_frac);
      s2_wts[bts_pkg::C10] <= WW'(s_frac) * WW'(t_inv);
      s2_wts[bts_pkg::C00] <= WW'(s_inv)  * WW'(t_inv);
      s2_waddr <= s1_waddr;
      s2_wdata <= s1_wdata;
    end
  end

  // stage 3
  logic [SW-1:0] a00, a10, a01, a11;

  assign a00 = SW'(s2_x0) + SW'(s2_wy0);
  assign a10 = a00 + SW'(s2_sx);
  assign a01 = a00 + (s2_ty ? SW'(eff_w) : '0);
  assign a11 = a01 + SW'(s2_sx);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl <= '0;
    end else if (adv) begin
      s3_ctl <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_raddr[bts_pkg::C00] <= a00[AW-1:0];
      s3_raddr[bts_pkg::C10] <= a10[AW-1:0];
      s3_raddr[bts_pkg::C01] <= a01[AW-1:0];
      s3_raddr[bts_pkg::C11] <= a11[AW-1:0];
      s3_wts   <= s2_wts;
      s3_waddr <= s2_waddr;
      s3_wdata <= s2_wdata;
    end
  end

endmodule

FILE: rtl/bts_texmem.sv
// Texel store: two copies, each with one write and two registered reads,
// giving four corner reads per cycle. Depends on bts_pkg.
module bts_texmem #(
  parameter int TEXEL_DEPTH = 65536,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  bts_pkg::stage_ctl_t                 s3_ctl,
  input  logic [$clog2(TEXEL_DEPTH)-1:0]      s3_waddr,
  input  bts_pkg::texel_t                     s3_wdata,
  input  logic [bts_pkg::CORNERS-1:0][$clog2(TEXEL_DEPTH)-1:0] s3_raddr,
  input  logic [bts_pkg::CORNERS-1:0][2*FRAC_BITS:0]           s3_wts,
  output bts_pkg::stage_ctl_t                 s4_ctl,
  output bts_pkg::texel_t [bts_pkg::CORNERS-1:0]               s4_texel,
  output logic [bts_pkg::CORNERS-1:0][2*FRAC_BITS:0]           s4_wts
);

  localparam int AW    = $clog2(TEXEL_DEPTH);
  localparam int DEPTH = 1 << AW;

  bts_pkg::texel_t mem_lo [DEPTH];
  bts_pkg::texel_t mem_hi [DEPTH];
  bts_pkg::texel_t rd00, rd10, rd01, rd11;
  logic            wr_en;

  assign wr_en = adv && s3_ctl.valid && !s3_ctl.sample;

  // row y0 corners
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lo[s3_waddr] <= s3_wdata;
    end
    if (adv) begin
      rd00 <= mem_lo[s3_raddr[bts_pkg::C00]];
      rd10 <= mem_lo[s3_raddr[bts_pkg::C10]];
    end
  end

  // row y1 corners
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_hi[s3_waddr] <= s3_wdata;
    end
    if (adv) begin
      rd01 <= mem_hi[s3_raddr[bts_pkg::C01]];
      rd11 <= mem_hi[s3_raddr[bts_pkg::C11]];
    end
  end

  always_comb begin
    s4_texel[bts_pkg::C00] = rd00;
    s4_texel[bts_pkg::C10] = rd10;
    s4_texel[bts_pkg::C01] = rd01;
    s4_texel[bts_pkg::C11] = rd11;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl <= '0;
    end else if (adv) begin
      s4_ctl <= s3_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_wts <= s3_wts;
    end
  end

endmodule

FILE: rtl/bts_blend.sv
// Blend: weight times texel products per channel and corner, then the
// four-way sum with rounding. Depends on bts_pkg.
module bts_blend #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       adv,
  input  bts_pkg::stage_ctl_t                        s4_ctl,
  input  bts_pkg::texel_t [bts_pkg::CORNERS-1:0]     s4_texel,
  input  logic [bts_pkg::CORNERS-1:0][2*FRAC_BITS:0] s4_wts,
  output bts_pkg::stage_ctl_t                        s5_ctl,
  output logic [bts_pkg::RESULT_W-1:0]               red_out,
  output logic [bts_pkg::RESULT_W-1:0]               green_out,
  output logic [bts_pkg::RESULT_W-1:0]               blue_out
);

  localparam int WW   = 2*FRAC_BITS + 1;
  localparam int PW   = WW + bts_pkg::CHAN_W;
  localparam int ACCW = PW + 2;
  localparam int RW   = (ACCW + 1 > FRAC_BITS + bts_pkg::RESULT_W) ?
                        ACCW + 1 : FRAC_BITS + bts_pkg::RESULT_W;

  logic [PW-1:0] prod_r [bts_pkg::CORNERS];
  logic [PW-1:0] prod_g [bts_pkg::CORNERS];
  logic [PW-1:0] prod_b [bts_pkg::CORNERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_ctl <= '0;
    end else if (adv) begin
      s5_ctl <= s4_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < bts_pkg::CORNERS; k++) begin
        prod_r[k] <= PW'(s4_wts[k]) * PW'(s4_texel[k].red);
        prod_g[k] <= PW'(s4_wts[k]) * PW'(s4_texel[k].green);
        prod_b[k] <= PW'(s4_wts[k]) * PW'(s4_texel[k].blue);
      end
    end
  end

  logic [RW-1:0] half, acc_r, acc_g, acc_b;

  assign half  = RW'(1) << (FRAC_BITS - 1);
  assign acc_r = RW'(prod_r[0]) + RW'(prod_r[1]) + RW'(prod_r[2]) + RW'(prod_r[3]) + half;
  assign acc_g = RW'(prod_g[0]) + RW'(prod_g[1]) + RW'(prod_g[2]) + RW'(prod_g[3]) + half;
  assign acc_b = RW'(prod_b[0]) + RW'(prod_b[1]) + RW'(prod_b[2]) + RW'(prod_b[3]) + half;

  assign red_out   = acc_r[FRAC_BITS +: bts_pkg::RESULT_W];
  assign green_out = acc_g[FRAC_BITS +: bts_pkg::RESULT_W];
  assign blue_out  = acc_b[FRAC_BITS +: bts_pkg::RESULT_W];

endmodule
